FILE: rtl/srs1_pkg.sv
// shared types, constants and character codes for the s1 record loader
package srs1_pkg;

    localparam int LINE_CHARS  = 80;
    localparam int COL_W       = $clog2(LINE_CHARS);
    localparam int STORE_DEPTH = 35;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int DEC_W       = $clog2(STORE_DEPTH + 1);

    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] ALPHA_OFS = 8'd55;

    localparam logic [7:0] MIN_COUNT = 8'd3;

    localparam logic       KIND_WRITE   = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;

    localparam logic [1:0] STATUS_LOADED  = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_SHORT   = 2'd2;

    typedef struct packed {
        logic [7:0] character;
        logic       file_start;
    } req_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [1:0]  line_status;
        logic [5:0]  record_bytes;
        logic [15:0] total_bytes;
        logic        last;
    } res_t;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } mem_wr_t;

    typedef struct packed {
        logic              valid;
        logic [DEC_W-1:0]  count;
        logic [15:0]       address;
        logic [1:0]        status;
        logic [15:0]       total;
    } line_end_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_SUMMARY
    } drain_state_t;

endpackage

FILE: rtl/srecord_s1_loader_unit.sv
// top level of the s1 record loader
//
// usage: characters of a record file enter on the req channel (valid/ready),
// one per request; file_start clears the running total and the line state
// before its character is handled. results leave on the res channel as
// write results (address, data) followed by one line summary with last set.
// ordinary characters are taken one per cycle while the drain sequencer is
// idle and give no result. a newline hands the line to the drain sequencer,
// which for each stored data byte reads the record store (registered read)
// and then loads the byte into the result register, and after the last byte
// loads the summary, while req_ready stays low. a stalled res channel holds
// the result register and the sequencer waits. reset clears line state, the
// running total, the drain state and the result valid flag; the record
// store is not cleared, since only bytes written in the same line are
// ever read back.
module srecord_s1_loader_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  srs1_pkg::req_t req,
    output logic           res_valid,
    input  logic           res_ready,
    output srs1_pkg::res_t res
);
    import srs1_pkg::*;

    logic                take;
    logic                idle;
    mem_wr_t             wr;
    line_end_t           line_end;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic [7:0]          rd_data;

    assign req_ready = idle;
    assign take      = req_valid && idle;

    srs1_line u_line (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .req      (req),
        .wr       (wr),
        .line_end (line_end)
    );

    srs1_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    srs1_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_end  (line_end),
        .rd_data   (rd_data),
        .res_ready (res_ready),
        .idle      (idle),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

FILE: rtl/srs1_store.sv
// data byte store of one record, synchronous write and registered read
module srs1_store (
    input  logic                    clk,
    input  srs1_pkg::mem_wr_t       wr,
    input  logic                    rd_en,
    input  logic [srs1_pkg::STORE_AW-1:0] rd_addr,
    output logic [7:0]              rd_data
);
    import srs1_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/srs1_line.sv
// per-line character decoder: header, count, address and data pairs
module srs1_line (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  srs1_pkg::req_t      req,
    output srs1_pkg::mem_wr_t   wr,
    output srs1_pkg::line_end_t line_end
);
    import srs1_pkg::*;

    logic [COL_W-1:0] column_reg, column_next;
    logic             record_ok_reg, record_ok_next;
    logic [3:0]       high_digit_reg, high_digit_next;
    logic [7:0]       byte_count_reg, byte_count_next;
    logic [15:0]      load_address_reg, load_address_next;
    logic [DEC_W-1:0] decoded_reg, decoded_next;
    logic [15:0]      total_reg, total_next;

    logic [COL_W-1:0] col_eff;
    logic             ok_eff;
    logic [3:0]       high_eff;
    logic [7:0]       count_eff;
    logic [15:0]      addr_eff;
    logic [DEC_W-1:0] dec_eff;
    logic [15:0]      total_eff;
    logic [7:0]       val;
    logic [7:0]       pair;
    logic [COL_W-1:0] idx;
    logic [7:0]       want;
    logic             short_rec;
    logic [DEC_W-1:0] written;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg       <= '0;
            record_ok_reg    <= 1'b0;
            high_digit_reg   <= '0;
            byte_count_reg   <= '0;
            load_address_reg <= '0;
            decoded_reg      <= '0;
            total_reg        <= '0;
        end
        else
        begin
            column_reg       <= column_next;
            record_ok_reg    <= record_ok_next;
            high_digit_reg   <= high_digit_next;
            byte_count_reg   <= byte_count_next;
            load_address_reg <= load_address_next;
            decoded_reg      <= decoded_next;
            total_reg        <= total_next;
        end
    end

    always_comb
    begin
        col_eff   = req.file_start ? '0 : column_reg;
        ok_eff    = req.file_start ? 1'b0 : record_ok_reg;
        high_eff  = req.file_start ? '0 : high_digit_reg;
        count_eff = req.file_start ? '0 : byte_count_reg;
        addr_eff  = req.file_start ? '0 : load_address_reg;
        dec_eff   = req.file_start ? '0 : decoded_reg;
        total_eff = req.file_start ? '0 : total_reg;

        if (req.character >= CH_ZERO && req.character <= CH_NINE)
        begin
            val = req.character - CH_ZERO;
        end
        else
        begin
            val = req.character - ALPHA_OFS;
        end
        pair = {high_eff, 4'h0} | val;
        idx  = COL_W'((col_eff - COL_W'(9)) >> 1);

        want      = (count_eff >= MIN_COUNT) ? 8'(count_eff - MIN_COUNT) : 8'd0;
        short_rec = (int'(col_eff) < 8) || (count_eff < MIN_COUNT);
        if (want > 8'(dec_eff))
        begin
            want      = 8'(dec_eff);
            short_rec = 1'b1;
        end
        written = (ok_eff && int'(col_eff) >= 2) ? DEC_W'(want) : '0;

        column_next       = column_reg;
        record_ok_next    = record_ok_reg;
        high_digit_next   = high_digit_reg;
        byte_count_next   = byte_count_reg;
        load_address_next = load_address_reg;
        decoded_next      = decoded_reg;
        total_next        = total_reg;

        wr       = '0;
        wr.addr  = STORE_AW'(idx);
        wr.data  = pair;
        line_end = '0;

        if (take)
        begin
            column_next       = col_eff;
            record_ok_next    = ok_eff;
            high_digit_next   = high_eff;
            byte_count_next   = count_eff;
            load_address_next = addr_eff;
            decoded_next      = dec_eff;
            total_next        = total_eff;

            if (req.character == CH_LF)
            begin
                line_end.valid   = 1'b1;
                line_end.count   = written;
                line_end.address = addr_eff;
                line_end.total   = 16'(total_eff + 16'(written));
                if (ok_eff && int'(col_eff) >= 2)
                begin
                    line_end.status = short_rec ? STATUS_SHORT : STATUS_LOADED;
                end
                else
                begin
                    line_end.status = STATUS_IGNORED;
                end
                total_next        = line_end.total;
                column_next       = '0;
                record_ok_next    = 1'b0;
                high_digit_next   = '0;
                byte_count_next   = '0;
                load_address_next = '0;
                decoded_next      = '0;
            end
            else if (req.character != CH_CR && col_eff < COL_W'(LINE_CHARS - 1))
            begin
                column_next = COL_W'(col_eff + COL_W'(1));
                if (col_eff == COL_W'(0))
                begin
                    record_ok_next = (req.character == CH_S);
                end
                else if (col_eff == COL_W'(1))
                begin
                    record_ok_next = ok_eff && (req.character == CH_ONE);
                end
                else if (!col_eff[0])
                begin
                    high_digit_next = val[3:0];
                end
                else if (col_eff == COL_W'(3))
                begin
                    byte_count_next = pair;
                end
                else if (col_eff == COL_W'(5))
                begin
                    load_address_next = {pair, 8'd0};
                end
                else if (col_eff == COL_W'(7))
                begin
                    load_address_next = {addr_eff[15:8], pair};
                end
                else if (int'(idx) < STORE_DEPTH)
                begin
                    wr.en        = 1'b1;
                    decoded_next = DEC_W'(idx + COL_W'(1));
                end
            end
        end
    end

endmodule

FILE: rtl/srs1_drain.sv
// end of line sequencer: reads stored bytes back and emits writes and summary
module srs1_drain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  srs1_pkg::line_end_t           line_end,
    input  logic [7:0]                    rd_data,
    input  logic                          res_ready,
    output logic                          idle,
    output logic                          rd_en,
    output logic [srs1_pkg::STORE_AW-1:0] rd_addr,
    output logic                          res_valid,
    output srs1_pkg::res_t                res
);
    import srs1_pkg::*;

    drain_state_t     state_reg, state_next;
    logic [DEC_W-1:0] idx_reg, idx_next;
    logic [DEC_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      addr_reg, addr_next;
    logic [1:0]       status_reg, status_next;
    logic [15:0]      total_reg, total_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;
    logic             out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
        total_reg  <= total_next;
        out_reg    <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        status_next    = status_reg;
        total_next     = total_reg;
        out_next       = out_reg;
        out_free       = !out_valid_reg || res_ready;
        out_valid_next = out_valid_reg && !res_ready;
        rd_en          = 1'b0;
        rd_addr        = STORE_AW'(idx_reg);
        idle           = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (line_end.valid)
                begin
                    idx_next    = '0;
                    cnt_next    = line_end.count;
                    addr_next   = line_end.address;
                    status_next = line_end.status;
                    total_next  = line_end.total;
                    state_next  = (line_end.count != '0) ? ST_READ : ST_SUMMARY;
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_next               = '0;
                    out_next.result_kind   = KIND_WRITE;
                    out_next.write_address = addr_reg;
                    out_next.write_data    = rd_data;
                    out_valid_next         = 1'b1;
                    idx_next               = DEC_W'(idx_reg + DEC_W'(1));
                    addr_next              = 16'(addr_reg + 16'd1);
                    state_next = (idx_next == cnt_reg) ? ST_SUMMARY : ST_READ;
                end
            end
            ST_SUMMARY:
            begin
                if (out_free)
                begin
                    out_next              = '0;
                    out_next.result_kind  = KIND_SUMMARY;
                    out_next.line_status  = status_reg;
                    out_next.record_bytes = 6'(cnt_reg);
                    out_next.total_bytes  = total_reg;
                    out_next.last         = 1'b1;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the s1 record loader: directed lines, random records, stalls
module testbench;

    import srs1_pkg::*;

    localparam int NUM_LINES    = 18;
    localparam int RAND_CHARS   = 175;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic       fs_en;
        logic [6:0] fs_pos;
        logic       lead_en;
        logic [7:0] lead;
        logic       typed;
        logic [1:0] status;
        logic [5:0] nbytes;
        logic [15:0] total;
    } line_plan_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    bit res_hold_req = 1'b0;

    // line decoder mirror
    int         line_col;
    bit         line_is_s1;
    logic [7:0] pair_high;
    logic [7:0] rec_count;
    logic [15:0] rec_address;
    int         rec_nbytes;
    logic [7:0] rec_data [STORE_DEPTH];
    logic [15:0] loaded_total;

    res_t       due_results [$];
    logic [7:0] line_buf [$];

    string line_text [NUM_LINES] = '{
        "",
        "S",
        "",
        "S1",
        "S1",
        "S102FFFF",
        "s1050000AB",
        "S2050000AB",
        "S1061234FF005A",
        "S105FFFF01\r02C4",
        "S1040010AB7",
        "S1050020AB",
        "S10512",
        "S126800000112233445566778899AABBCCDDEEFF0123456789ABCDEFFEDCBA9876543210A5C3E100",
        "S1FFFFF000112233445566778899AABBCCDDEEFF0123456789ABCDEFFEDCBA9876543210A5C3E1ZZZZZZ",
        "XYS1050040CAFE",
        "\r",
        "S103ABCD"
    };

    line_plan_t line_plan [NUM_LINES] = '{
        '{1, 0, 0, 8'h00, 1, STATUS_IGNORED, 0, 0},
        '{0, 0, 0, 8'h00, 1, STATUS_IGNORED, 0, 0},
        '{0, 0, 1, 8'h00, 1, STATUS_IGNORED, 0, 0},
        '{0, 0, 1, 8'hFF, 1, STATUS_IGNORED, 0, 0},
        '{0, 0, 0, 8'h00, 1, STATUS_SHORT, 0, 0},
        '{0, 0, 0, 8'h00, 1, STATUS_SHORT, 0, 0},
        '{0, 0, 0, 8'h00, 1, STATUS_IGNORED, 0, 0},
        '{0, 0, 0, 8'h00, 1, STATUS_IGNORED, 0, 0},
        '{0, 0, 0, 8'h00, 0, STATUS_LOADED, 0, 0},
        '{0, 0, 0, 8'h00, 0, STATUS_LOADED, 0, 0},
        '{0, 0, 0, 8'h00, 0, STATUS_LOADED, 0, 0},
        '{0, 0, 0, 8'h00, 0, STATUS_LOADED, 0, 0},
        '{0, 0, 0, 8'h00, 1, STATUS_SHORT, 0, 7},
        '{0, 0, 0, 8'h00, 0, STATUS_LOADED, 0, 0},
        '{0, 0, 0, 8'h00, 0, STATUS_LOADED, 0, 0},
        '{1, 2, 0, 8'h00, 0, STATUS_LOADED, 0, 0},
        '{0, 0, 0, 8'h00, 1, STATUS_IGNORED, 0, 2},
        '{0, 0, 0, 8'h00, 1, STATUS_LOADED, 0, 2}
    };

    srecord_s1_loader_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] hex_nibble(input logic [7:0] ch);
        if (ch >= CH_ZERO && ch <= CH_NINE)
            return ch - CH_ZERO;
        return ch - ALPHA_OFS;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10)
            return CH_ZERO + 8'(n);
        return (($urandom_range(0, 15) == 0) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    task automatic forget_line();
        line_col = 0;
        line_is_s1 = 1'b0;
        pair_high = '0;
        rec_count = '0;
        rec_address = '0;
        rec_nbytes = 0;
    endtask

    task automatic decode_character(input req_t item);
        res_t       sum;
        res_t       wr;
        int         want;
        bit         short_rec;
        logic [7:0] pair;
        if (item.file_start)
        begin
            loaded_total = '0;
            forget_line();
        end
        if (item.character == CH_LF)
        begin
            want = 0;
            sum = '0;
            sum.line_status = STATUS_IGNORED;
            if (line_is_s1 && line_col >= 2)
            begin
                short_rec = (line_col < 8) || (rec_count < MIN_COUNT);
                want = (rec_count >= MIN_COUNT) ? int'(rec_count - MIN_COUNT) : 0;
                if (want > rec_nbytes)
                begin
                    want = rec_nbytes;
                    short_rec = 1'b1;
                end
                sum.line_status = short_rec ? STATUS_SHORT : STATUS_LOADED;
                for (int i = 0; i < want; i++)
                begin
                    wr = '0;
                    wr.result_kind = KIND_WRITE;
                    wr.write_address = rec_address + 16'(i);
                    wr.write_data = rec_data[i];
                    due_results.push_back(wr);
                end
            end
            loaded_total = loaded_total + 16'(want);
            sum.result_kind = KIND_SUMMARY;
            sum.record_bytes = 6'(want);
            sum.total_bytes = loaded_total;
            sum.last = 1'b1;
            due_results.push_back(sum);
            forget_line();
        end
        else if (item.character != CH_CR && line_col < LINE_CHARS - 1)
        begin
            pair = {pair_high[3:0], 4'h0} | hex_nibble(item.character);
            if (line_col == 0)
                line_is_s1 = (item.character == CH_S);
            else if (line_col == 1)
                line_is_s1 = line_is_s1 && (item.character == CH_ONE);
            else if (line_col % 2 == 0)
                pair_high = hex_nibble(item.character);
            else if (line_col == 3)
                rec_count = pair;
            else if (line_col == 5)
                rec_address = {pair, 8'h00};
            else if (line_col == 7)
                rec_address[7:0] = pair;
            else if ((line_col - 9) / 2 < STORE_DEPTH)
            begin
                rec_data[(line_col - 9) / 2] = pair;
                rec_nbytes = (line_col - 9) / 2 + 1;
            end
            line_col++;
        end
    endtask

    task automatic push_char(input logic [7:0] ch, input logic fs);
        req_t item;
        bit   taken;
        item.character = ch;
        item.file_start = fs;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
        begin
            @(negedge clk);
            taken = req_ready;
            @(posedge clk);
        end
        while (!taken);
        decode_character(item);
    endtask

    task automatic add_hex(input logic [7:0] b);
        line_buf.push_back(hex_char(b[7:4]));
        line_buf.push_back(hex_char(b[3:0]));
    endtask

    task automatic make_line();
        int          kind;
        int          n;
        int          cut;
        logic [7:0]  cnt;
        logic [15:0] addr;
        line_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 35) : $urandom_range(0, 6);
            cnt = 8'(n + 3);
            case ($urandom_range(0, 7))
                0: cnt = 8'($urandom_range(0, 2));
                1: cnt = cnt + 8'($urandom_range(1, 4));
                default: ;
            endcase
            addr = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 8))
                                               : 16'($urandom);
            line_buf.push_back(CH_S);
            line_buf.push_back(CH_ONE);
            add_hex(cnt);
            add_hex(addr[15:8]);
            add_hex(addr[7:0]);
            repeat (n) add_hex(8'($urandom));
            add_hex(8'($urandom));
            if ($urandom_range(0, 7) == 0)
            begin
                cut = $urandom_range(0, line_buf.size() - 1);
                while (line_buf.size() > cut)
                    void'(line_buf.pop_back());
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 40)) line_buf.push_back(hex_char(4'($urandom)));
            if ($urandom_range(0, 4) == 0)
                line_buf.insert($urandom_range(0, line_buf.size()), CH_CR);
        end
        else if (kind <= 7)
            repeat ($urandom_range(0, 24)) line_buf.push_back(8'($urandom_range(0, 255)));
        else if (kind == 8)
        begin
            line_buf.push_back(CH_S);
            line_buf.push_back(CH_ONE);
            repeat ($urandom_range(0, 10)) line_buf.push_back(8'($urandom_range(32, 126)));
        end
        else
        begin
            line_buf.push_back(CH_S);
            line_buf.push_back(hex_char(4'($urandom)));
            repeat ($urandom_range(4, 20)) line_buf.push_back(hex_char(4'($urandom)));
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (due_results.size() == 0)
        begin
            errors++;
            $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
            return;
        end
        want = due_results.pop_front();
        compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
        compare_field("write_address", want.write_address, got.write_address);
        compare_field("write_data", 16'(want.write_data), 16'(got.write_data));
        compare_field("line_status", 16'(want.line_status), 16'(got.line_status));
        compare_field("record_bytes", 16'(want.record_bytes), 16'(got.record_bytes));
        compare_field("total_bytes", want.total_bytes, got.total_bytes);
        compare_field("last", 16'(want.last), 16'(got.last));
    endtask

    always @(negedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            check_result(res);
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_hold_req)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_hold_req = 1'b0;
                res_ready <= 1'b1;
            end
            else
                res_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        #5000000;
        $display("srecord_s1_loader_unit regression: fail");
        $finish;
    end

    initial
    begin
        line_plan_t plan;
        res_t       typed_sum;
        int         rand_sent;
        int         phase;
        forget_line();
        loaded_total = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_LINES; r++)
        begin
            plan = line_plan[r];
            if (plan.lead_en)
                push_char(plan.lead, 1'b0);
            for (int i = 0; i < line_text[r].len(); i++)
                push_char(line_text[r][i], plan.fs_en && plan.fs_pos == i);
            push_char(CH_LF, plan.fs_en && plan.fs_pos == line_text[r].len());
            if (plan.typed)
            begin
                typed_sum = '0;
                typed_sum.result_kind = KIND_SUMMARY;
                typed_sum.line_status = plan.status;
                typed_sum.record_bytes = plan.nbytes;
                typed_sum.total_bytes = plan.total;
                typed_sum.last = 1'b1;
                void'(due_results.pop_back());
                due_results.push_back(typed_sum);
            end
        end

        rand_sent = 0;
        res_hold_req = 1'b1;
        while (rand_sent < RAND_CHARS)
        begin
            phase = rand_sent * 4 / RAND_CHARS;
            idle_pct = (phase == 1) ? 72 : (phase == 3) ? 7 : 0;
            stall_pct = (phase == 2) ? 72 : (phase == 3) ? 7 : 0;
            make_line();
            line_buf.push_back(CH_LF);
            foreach (line_buf[i])
            begin
                push_char(line_buf[i], $urandom_range(0, 59) == 0);
                rand_sent++;
            end
        end
        req_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("srecord_s1_loader_unit regression: pass");
        else
            $display("srecord_s1_loader_unit regression: fail");
        $finish;
    end

endmodule
